// ----- rtl/core/subsequence_occurrence_counter_top_assert.svh -----
// Assertion macros shared by the checker of the subsequence occurrence counter.
`ifndef SUBSEQUENCE_OCCURRENCE_COUNTER_TOP_ASSERT_SVH
`define SUBSEQUENCE_OCCURRENCE_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and switched off while rst_ni is low.
`define SOC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and switched off while rst_ni is low.
`define SOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/soc_pkg.sv -----
// Shared constants and types of the subsequence occurrence counter.
`default_nettype none

package soc_pkg;

  // Fixed widths of the channel fields.
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned SYMBOL_W = 16;
  localparam int unsigned MATCH_W  = 32;
  localparam int unsigned PLEN_W   = 5;

  // Default build of the block.
  localparam int unsigned MAX_PATTERN_DEF = 16;
  localparam int unsigned SYMBOL_BITS_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF  = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2
  } soc_cmd_e;

endpackage

`default_nettype wire

// ----- rtl/core/soc_if.sv -----
// Valid/ready channel interfaces for the command input and the result output.
`default_nettype none

interface soc_in_if;
  logic                          valid;
  logic                          ready;
  logic [soc_pkg::CMD_W-1:0]     command;
  logic [soc_pkg::SYMBOL_W-1:0]  symbol;
  logic                          end_of_text;

  modport source (output valid, output command, output symbol, output end_of_text,
                  input ready);
  modport sink   (input valid, input command, input symbol, input end_of_text,
                  output ready);
endinterface

interface soc_out_if;
  logic                         valid;
  logic                         ready;
  logic [soc_pkg::MATCH_W-1:0]  match_count;
  logic                         saturated;
  logic [soc_pkg::PLEN_W-1:0]   pattern_length;
  logic                         pattern_overflow;
  logic                         final_res;

  modport source (output valid, output match_count, output saturated,
                  output pattern_length, output pattern_overflow, output final_res,
                  input ready);
  modport sink   (input valid, input match_count, input saturated,
                  input pattern_length, input pattern_overflow, input final_res,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/subsequence_occurrence_counter_top.sv -----
// Subsequence occurrence counter: counts in-order, gapped matches of a stored pattern.
//
// Usage. Commands arrive on in_i, a valid/ready channel; a transfer takes place on a
// rising edge of clk_i with valid and ready both high. A clear command empties the
// pattern and zeroes the counts, an append command stores one pattern symbol and
// restarts the counts, and a text command advances every prefix count at once.
// Every command yields exactly one result transfer on out_o carrying the count of
// full-pattern occurrences, its saturation flag, the stored pattern length, the
// overflow flag of a dropped append and an echo of end_of_text.
// Timing. A command is first captured in an input register; the prefix count update
// (one saturating add per pattern position and a select of the longest prefix) then
// runs combinationally into the result register, which offers the result on out_o.
// One command is taken every cycle for as long as the receiver keeps ready high.
// Stalls. When out_o.ready is low the result register holds its contents, the input
// register fills, and in_i.ready drops until the result has been taken.
// Reset. rst_ni is asynchronous and active low: both channel stages empty, the
// pattern length returns to zero and all prefix counts are cleared. The pattern
// symbols themselves are not reset; only entries below the stored length are used.
`default_nettype none

module subsequence_occurrence_counter_top #(
  parameter int unsigned MAX_PATTERN = soc_pkg::MAX_PATTERN_DEF,
  parameter int unsigned SYMBOL_BITS = soc_pkg::SYMBOL_BITS_DEF,
  parameter int unsigned COUNT_BITS  = soc_pkg::COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  soc_in_if.sink     in_i,
  soc_out_if.source  out_o
);

  // Only the low bits of the symbol field that fit the configured symbol width matter.
  localparam int unsigned SymW = (SYMBOL_BITS < soc_pkg::SYMBOL_W) ?
                                 SYMBOL_BITS : soc_pkg::SYMBOL_W;
  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);
  localparam logic [COUNT_BITS-1:0] CntMax = '1;
  localparam logic [LenW-1:0]       LenFull = LenW'(MAX_PATTERN);

  // Input register.
  logic                         in_valid_q;
  logic [soc_pkg::CMD_W-1:0]    cmd_q;
  logic [SymW-1:0]              sym_q;
  logic                         eot_q;

  // Block state.
  logic [SymW-1:0]              pat_q [MAX_PATTERN];
  logic [LenW-1:0]              len_q, len_d;
  logic [COUNT_BITS-1:0]        cnt_q [MAX_PATTERN];
  logic [COUNT_BITS-1:0]        cnt_d [MAX_PATTERN];

  // Result register.
  logic                         out_valid_q;
  logic [soc_pkg::MATCH_W-1:0]  match_q;
  logic                         sat_q;
  logic [soc_pkg::PLEN_W-1:0]   plen_q;
  logic                         ovf_q;
  logic                         fin_q;

  logic                         advance;
  logic                         in_ready;
  logic                         fire;

  // Datapath signals.
  logic [COUNT_BITS-1:0]        cnt_upd [MAX_PATTERN];
  logic [COUNT_BITS-1:0]        cnt_res [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]       pat_we;
  logic                         ovf_d;
  logic [COUNT_BITS-1:0]        count_d;
  logic [COUNT_BITS+soc_pkg::MATCH_W-1:0] count_ext;
  logic [LenW+soc_pkg::PLEN_W-1:0]        len_ext;

  // The result stage moves on when it is empty or its contents are being taken;
  // the input stage can then always take a new command.
  assign advance  = !out_valid_q || out_o.ready;
  assign in_ready = !in_valid_q || advance;
  assign fire     = in_valid_q && advance;

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      cmd_q <= in_i.command;
      sym_q <= in_i.symbol[SymW-1:0];
      eot_q <= in_i.end_of_text;
    end
  end

  // Per-position update: a prefix grows by the old count of the prefix one shorter
  // (or by one for the first position) when its last symbol matches the text symbol.
  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_prefix
    logic                   hit;
    logic [COUNT_BITS-1:0]  inc;
    logic [COUNT_BITS:0]    sum;

    if (g == 0) begin : g_first
      assign inc = COUNT_BITS'(1);
    end else begin : g_rest
      assign inc = cnt_q[g-1];
    end

    assign hit = (pat_q[g] == sym_q) && (LenW'(g) < len_q);
    assign sum = {1'b0, cnt_q[g]} + {1'b0, inc};
    assign cnt_upd[g] = !hit ? cnt_q[g] :
                        (sum[COUNT_BITS] ? CntMax : sum[COUNT_BITS-1:0]);
  end

  always_comb begin
    len_d  = len_q;
    ovf_d  = 1'b0;
    pat_we = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      cnt_res[k] = cnt_q[k];
    end

    unique case (cmd_q)
      soc_pkg::CMD_CLEAR: begin
        len_d = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
          cnt_res[k] = '0;
        end
      end
      soc_pkg::CMD_APPEND: begin
        if (len_q < LenFull) begin
          len_d = len_q + LenW'(1);
          for (int k = 0; k < MAX_PATTERN; k++) begin
            pat_we[k] = (len_q == LenW'(k));
          end
        end else begin
          ovf_d = 1'b1;
        end
        for (int k = 0; k < MAX_PATTERN; k++) begin
          cnt_res[k] = '0;
        end
      end
      soc_pkg::CMD_TEXT: begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
          cnt_res[k] = cnt_upd[k];
        end
      end
      default: begin
        // Unused command: state stays as it is and the status is reported.
      end
    endcase

    // Count of the whole pattern; the empty pattern occurs exactly once.
    count_d = COUNT_BITS'(1);
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (len_d == LenW'(k + 1)) begin
        count_d = cnt_res[k];
      end
    end

    // The last symbol of a text reports its count, then the counts start afresh.
    for (int k = 0; k < MAX_PATTERN; k++) begin
      cnt_d[k] = (cmd_q == soc_pkg::CMD_TEXT && eot_q) ? '0 : cnt_res[k];
    end
  end

  assign count_ext = (COUNT_BITS + soc_pkg::MATCH_W)'(count_d);
  assign len_ext   = (LenW + soc_pkg::PLEN_W)'(len_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (fire) begin
      len_q <= len_d;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        cnt_q[k] <= cnt_d[k];
      end
    end
  end

  // Pattern symbols carry no reset: entries at or above the length are never used.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (fire && pat_we[k]) begin
        pat_q[k] <= sym_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      match_q <= count_ext[soc_pkg::MATCH_W-1:0];
      sat_q   <= (count_d == CntMax);
      plen_q  <= len_ext[soc_pkg::PLEN_W-1:0];
      ovf_q   <= ovf_d;
      fin_q   <= eot_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.match_count      = match_q;
  assign out_o.saturated        = sat_q;
  assign out_o.pattern_length   = plen_q;
  assign out_o.pattern_overflow = ovf_q;
  assign out_o.final_res        = fin_q;

endmodule

`default_nettype wire

// ----- rtl/core/soc_checker.sv -----
// Port-level checker of the subsequence occurrence counter and its bind statement.
`default_nettype none

`include "subsequence_occurrence_counter_top_assert.svh"

module soc_checker #(
  parameter int unsigned MAX_PATTERN = soc_pkg::MAX_PATTERN_DEF,
  parameter int unsigned COUNT_BITS  = soc_pkg::COUNT_BITS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [soc_pkg::MATCH_W-1:0]  match_count_i,
  input logic                         saturated_i,
  input logic [soc_pkg::PLEN_W-1:0]   pattern_length_i,
  input logic                         pattern_overflow_i
);

  localparam logic [63:0] CntMax64 = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COUNT_BITS);
  localparam logic [soc_pkg::MATCH_W-1:0] CntMaxOut = CntMax64[soc_pkg::MATCH_W-1:0];
  localparam logic [soc_pkg::PLEN_W-1:0]  FullLen   = soc_pkg::PLEN_W'(MAX_PATTERN);

  // A stalled result is held until it is taken.
  `SOC_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(match_count_i), "stalled result changed")

  // The input side only pushes back while a result is waiting to be taken.
  `SOC_ASSERT_NOW(a_in_backpressure, !in_ready_i && in_valid_i, out_valid_i && !out_ready_i, "input stalled without an output stall")

  // A dropped append can only happen with a full pattern store.
  `SOC_ASSERT_NOW(a_overflow_full, out_valid_i && pattern_overflow_i, pattern_length_i == FullLen, "overflow reported below full length")

  // The saturation flag goes with the maximum count.
  `SOC_ASSERT_NOW(a_sat_max, out_valid_i && saturated_i, match_count_i == CntMaxOut, "saturated flag without maximum count")

endmodule

bind subsequence_occurrence_counter_top soc_checker #(
  .MAX_PATTERN (MAX_PATTERN),
  .COUNT_BITS  (COUNT_BITS)
) u_soc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .match_count_i      (out_o.match_count),
  .saturated_i        (out_o.saturated),
  .pattern_length_i   (out_o.pattern_length),
  .pattern_overflow_i (out_o.pattern_overflow)
);

`default_nettype wire

// ----- tb/subsequence_occurrence_counter_top_tb.sv -----
// Self-checking testbench of the subsequence occurrence counter with a random command stream.
`default_nettype none

module subsequence_occurrence_counter_top_tb;

  // Local copies of the package widths.
  localparam int unsigned CMD_W    = soc_pkg::CMD_W;
  localparam int unsigned SYMBOL_W = soc_pkg::SYMBOL_W;
  localparam int unsigned MATCH_W  = soc_pkg::MATCH_W;
  localparam int unsigned PLEN_W   = soc_pkg::PLEN_W;

  // Command code that the block does not decode; it must leave all state alone.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned PATTERN_DEPTH = soc_pkg::MAX_PATTERN_DEF;
  localparam int unsigned RANDOM_ITEMS  = 1150;
  // Cycles waited after the last result has come back, before the final check.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Cycle bound after which the watchdog ends the run.
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned MAX_REPORTS   = 30;

  typedef struct {
    logic [CMD_W-1:0]    command;
    logic [SYMBOL_W-1:0] symbol;
    logic                end_of_text;
    bit                  drain_first;  // hold the command back until all results are in
  } cmd_item_t;

  typedef struct {
    logic [MATCH_W-1:0] match_count;
    logic               saturated;
    logic [PLEN_W-1:0]  pattern_length;
    logic               pattern_overflow;
    logic               final_res;
  } tally_t;

  logic clk;
  logic rst_n;

  soc_in_if  in_ch ();
  soc_out_if out_ch ();

  subsequence_occurrence_counter_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Commands waiting to be sent, and the results that the accepted ones must produce.
  cmd_item_t command_queue[$];
  tally_t    expected_tallies[$];
  cmd_item_t in_flight;

  // Our own copy of the pattern and of the running prefix counts.
  logic [SYMBOL_W-1:0] pat_sym      [PATTERN_DEPTH];
  logic [MATCH_W-1:0]  prefix_tally [PATTERN_DEPTH];
  int unsigned         pat_len;

  int unsigned cycle_count;
  int unsigned n_sent;
  int unsigned n_recv;
  int unsigned mismatches;
  int unsigned n_text, n_append, n_dropped, n_clear, n_unused;
  int unsigned n_final, n_saturated, n_overflow, longest_pattern;

  // Sender and receiver pacing state.
  int unsigned gap_left, burst_left;
  int unsigned ready_mode, mode_left, stall_phase;
  logic [7:0]  stall_mask;

  task automatic flag_mismatch(input string what);
    if (mismatches < MAX_REPORTS) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    end
    mismatches++;
  endtask

  task automatic queue_cmd(input logic [CMD_W-1:0] c, input logic [SYMBOL_W-1:0] s,
                           input logic e, input bit d);
    cmd_item_t it;
    it.command     = c;
    it.symbol      = s;
    it.end_of_text = e;
    it.drain_first = d;
    command_queue.push_back(it);
  endtask

  // Applies one accepted command to our copy of the state and returns the result that
  // the block must report for it.
  function automatic tally_t predict_tally(input cmd_item_t it);
    tally_t             res;
    logic [MATCH_W:0]   sum;
    logic [MATCH_W-1:0] carry_in;
    res.pattern_overflow = 1'b0;
    case (it.command)
      soc_pkg::CMD_CLEAR: begin
        pat_len = 0;
        foreach (prefix_tally[k]) prefix_tally[k] = '0;
        n_clear++;
      end
      soc_pkg::CMD_APPEND: begin
        if (pat_len < PATTERN_DEPTH) begin
          pat_sym[pat_len] = it.symbol;
          pat_len++;
        end else begin
          // A full store drops the symbol, but the counts restart all the same.
          res.pattern_overflow = 1'b1;
          n_dropped++;
        end
        foreach (prefix_tally[k]) prefix_tally[k] = '0;
        n_append++;
      end
      soc_pkg::CMD_TEXT: begin
        // Highest prefix first, so each position still sees the old count below it.
        for (int k = PATTERN_DEPTH - 1; k >= 0; k--) begin
          if (k < pat_len && pat_sym[k] == it.symbol) begin
            if (k == 0) begin
              carry_in = MATCH_W'(1);
            end else begin
              carry_in = prefix_tally[k-1];
            end
            sum = {1'b0, prefix_tally[k]} + {1'b0, carry_in};
            prefix_tally[k] = sum[MATCH_W] ? '1 : sum[MATCH_W-1:0];
          end
        end
        n_text++;
      end
      default: begin
        n_unused++;
      end
    endcase
    // The empty pattern occurs exactly once in any text.
    if (pat_len == 0) begin
      res.match_count = MATCH_W'(1);
    end else begin
      res.match_count = prefix_tally[pat_len-1];
    end
    res.saturated      = (res.match_count == '1);
    res.pattern_length = PLEN_W'(pat_len);
    res.final_res      = it.end_of_text;
    if (pat_len > longest_pattern) longest_pattern = pat_len;
    // Closing a text starts the next one against the same pattern.
    if (it.command == soc_pkg::CMD_TEXT && it.end_of_text) begin
      foreach (prefix_tally[k]) prefix_tally[k] = '0;
    end
    return res;
  endfunction

  // Clock with a period of two time units.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Driver. The sender works in bursts of random length separated by random gaps; a
  // burst that ends with a zero gap runs straight into the next, which gives stretches
  // of back-to-back transfers. The model state advances at the moment of each transfer.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.command     <= soc_pkg::CMD_CLEAR;
      in_ch.symbol      <= '0;
      in_ch.end_of_text <= 1'b0;
      gap_left        = 0;
      burst_left      = 1;
      n_sent          = 0;
      pat_len         = 0;
      longest_pattern = 0;
      foreach (prefix_tally[i]) prefix_tally[i] = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_tallies.push_back(predict_tally(in_flight));
        n_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (command_queue.size() == 0 ||
                     (command_queue[0].drain_first && n_sent != n_recv)) begin
          // Either nothing left to send, or a pause until every result has come back.
          in_ch.valid <= 1'b0;
        end else begin
          in_flight = command_queue.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.command     <= in_flight.command;
          in_ch.symbol      <= in_flight.symbol;
          in_ch.end_of_text <= in_flight.end_of_text;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Monitor. Every result transfer is checked field by field against the oldest
  // expectation. The receiver moves between four stall patterns: always ready, random
  // half-rate, mostly stalled, and a repeating eight-bit mask.
  always @(posedge clk or negedge rst_n) begin
    tally_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      n_recv       <= 0;
      ready_mode  = 0;
      mode_left   = 0;
      stall_phase = 0;
      stall_mask  = 8'hFF;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_recv <= n_recv + 1;
        if (expected_tallies.size() == 0) begin
          flag_mismatch("result transfer with no command outstanding");
        end else begin
          want = expected_tallies.pop_front();
          if (out_ch.match_count !== want.match_count)
            flag_mismatch($sformatf("match_count %h, expected %h",
                                    out_ch.match_count, want.match_count));
          if (out_ch.saturated !== want.saturated)
            flag_mismatch($sformatf("saturated %b, expected %b",
                                    out_ch.saturated, want.saturated));
          if (out_ch.pattern_length !== want.pattern_length)
            flag_mismatch($sformatf("pattern_length %0d, expected %0d",
                                    out_ch.pattern_length, want.pattern_length));
          if (out_ch.pattern_overflow !== want.pattern_overflow)
            flag_mismatch($sformatf("pattern_overflow %b, expected %b",
                                    out_ch.pattern_overflow, want.pattern_overflow));
          if (out_ch.final_res !== want.final_res)
            flag_mismatch($sformatf("final_res %b, expected %b",
                                    out_ch.final_res, want.final_res));
          if (want.final_res) n_final++;
          if (want.saturated) n_saturated++;
          if (want.pattern_overflow) n_overflow++;
        end
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(32, 256);
        stall_mask = 8'($urandom) | 8'h01;
      end
      mode_left--;
      stall_phase++;
      case (ready_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= stall_mask[stall_phase % 8];
      endcase
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    logic [SYMBOL_W-1:0] alphabet [4];
    logic [SYMBOL_W-1:0] sym;
    int unsigned pick, k, plen, nseq, tlen, reps;
    bit          drain;
    logic        eot;

    rst_n = 1'b0;

    // Directed opening. With an empty pattern every text symbol reports one occurrence,
    // and a closing symbol is echoed as final.
    queue_cmd(soc_pkg::CMD_TEXT, 16'h0000, 1'b0, 1'b0);
    queue_cmd(soc_pkg::CMD_TEXT, 16'hFFFF, 1'b1, 1'b0);
    // A clear with end_of_text set only echoes the flag.
    queue_cmd(soc_pkg::CMD_CLEAR, 16'hFFFF, 1'b1, 1'b0);
    // Pattern of the two extreme symbols; the text counts ordered, gapped matches.
    queue_cmd(soc_pkg::CMD_APPEND, 16'h0000, 1'b0, 1'b0);
    queue_cmd(soc_pkg::CMD_APPEND, 16'hFFFF, 1'b0, 1'b0);
    queue_cmd(soc_pkg::CMD_TEXT, 16'hFFFF, 1'b0, 1'b0);
    queue_cmd(soc_pkg::CMD_TEXT, 16'h0000, 1'b0, 1'b0);
    queue_cmd(soc_pkg::CMD_TEXT, 16'hFFFF, 1'b0, 1'b0);
    queue_cmd(soc_pkg::CMD_TEXT, 16'hFFFF, 1'b1, 1'b0);
    // After the end of a text the counts start again from nothing.
    queue_cmd(soc_pkg::CMD_TEXT, 16'h0000, 1'b0, 1'b0);
    // The unused code reports the current status and changes nothing.
    queue_cmd(CMD_UNUSED, 16'h1234, 1'b1, 1'b0);
    // Fill the pattern store to the brim, then one more append is dropped.
    queue_cmd(soc_pkg::CMD_APPEND, 16'h5A5A, 1'b1, 1'b0);
    for (int i = 0; i < PATTERN_DEPTH - 3; i++) begin
      queue_cmd(soc_pkg::CMD_APPEND, (i % 2 == 0) ? 16'hA5A5 : SYMBOL_W'($urandom),
                1'b0, 1'b0);
    end
    queue_cmd(soc_pkg::CMD_APPEND, 16'h7FFF, 1'b0, 1'b0);
    queue_cmd(CMD_UNUSED, 16'h8000, 1'b0, 1'b0);
    queue_cmd(soc_pkg::CMD_CLEAR, 16'h0000, 1'b0, 1'b1);

    // Random part: mostly complete pattern-and-text sequences over a small alphabet, so
    // that matches are frequent, plus runs built to saturate, plus raw noise.
    while (command_queue.size() < RANDOM_ITEMS) begin
      pick  = $urandom_range(0, 99);
      drain = ($urandom_range(0, 19) == 0);
      if (pick < 10) begin
        // One repeated symbol in pattern and text makes the counts binomial, which
        // overruns the count width well within fifty text symbols.
        sym  = SYMBOL_W'($urandom);
        plen = $urandom_range(12, PATTERN_DEPTH);
        tlen = $urandom_range(40, 56);
        queue_cmd(soc_pkg::CMD_CLEAR, SYMBOL_W'($urandom), 1'b0, drain);
        for (int j = 0; j < plen; j++) queue_cmd(soc_pkg::CMD_APPEND, sym, 1'b0, 1'b0);
        for (int j = 0; j < tlen; j++) begin
          queue_cmd(soc_pkg::CMD_TEXT, sym, (j == tlen - 1), 1'b0);
        end
      end else if (pick < 80) begin
        k = $urandom_range(1, 4);
        foreach (alphabet[j]) alphabet[j] = SYMBOL_W'($urandom);
        if ($urandom_range(0, 1) == 1) begin
          queue_cmd(soc_pkg::CMD_CLEAR, SYMBOL_W'($urandom), ($urandom_range(0, 9) == 0),
                    drain);
          drain = 1'b0;
        end
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          plen = $urandom_range(1, 4);
        end else if (pick < 9) begin
          plen = $urandom_range(5, 10);
        end else begin
          plen = $urandom_range(14, 19);
        end
        for (int j = 0; j < plen; j++) begin
          queue_cmd(soc_pkg::CMD_APPEND, alphabet[$urandom_range(0, k - 1)],
                    ($urandom_range(0, 9) == 0), drain);
          drain = 1'b0;
        end
        nseq = $urandom_range(1, 3);
        for (int s = 0; s < nseq; s++) begin
          tlen = $urandom_range(1, 24);
          for (int t = 0; t < tlen; t++) begin
            sym = ($urandom_range(0, 7) == 0) ? SYMBOL_W'($urandom)
                                              : alphabet[$urandom_range(0, k - 1)];
            // The last text of a sequence is sometimes left open.
            eot = (t == tlen - 1) && !(s == nseq - 1 && $urandom_range(0, 4) == 0);
            queue_cmd(soc_pkg::CMD_TEXT, sym, eot, 1'b0);
          end
        end
      end else begin
        reps = $urandom_range(1, 10);
        for (int j = 0; j < reps; j++) begin
          queue_cmd(CMD_W'($urandom_range(0, 3)), SYMBOL_W'($urandom),
                    1'($urandom_range(0, 1)), (j == 0) && drain);
        end
      end
    end

    // Hold reset low, then release it on a rising edge.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge, where every update of the rising edge has settled.
    while (command_queue.size() != 0 || in_ch.valid) @(negedge clk);
    while (n_recv != n_sent) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (expected_tallies.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived",
                              expected_tallies.size()));

    $display("Sent %0d commands: %0d text, %0d append (%0d dropped), %0d clear, %0d unused.",
             n_sent, n_text, n_append, n_dropped, n_clear, n_unused);
    $display("Checked %0d results: %0d final, %0d saturated, %0d overflow, max length %0d.",
             n_recv, n_final, n_saturated, n_overflow, longest_pattern);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
